// ----- design/swhc_pkg.sv -----
// Shared widths, limits and controller/datapath handshake types for the hit counter.
package swhc_pkg;

    localparam int TS_W       = 31;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 25;
    localparam int MOD_STEPS  = 2;
    localparam int STEP_W     = $clog2(MOD_STEPS);
    localparam int WINDOW_DEF = 300;

    localparam logic MODE_HIT   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    typedef struct packed {
        logic load;      // capture timestamp, restart remainder
        logic mod_step;  // one remainder step
        logic idx_clr;   // rewind bucket index
        logic clr_wr;    // zero bucket at index, advance
        logic hit_rd;    // read bucket at slot
        logic hit_wr;    // write updated bucket at slot
        logic sum_rd;    // read bucket at index into sum pipe, advance
        logic sum_clr;   // zero accumulator
        logic out_load;  // move sum into output register
    } cmd_t;

    typedef struct packed {
        logic mod_done;  // current remainder step is the last
        logic idx_last;  // index is at the final bucket
        logic pipe_busy; // sum pipe still holds beats
        logic out_free;  // output register can take a new sum
    } status_t;

endpackage

// ----- design/swhc_item_if.sv -----
// Input channel: hit or query beat with its timestamp.
interface swhc_item_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [swhc_pkg::TS_W-1:0] timestamp;

    modport source (output valid, output mode, output timestamp, input ready);
    modport sink   (input valid, input mode, input timestamp, output ready);
endinterface

// ----- design/swhc_result_if.sv -----
// Output channel: windowed hit count for each query.
interface swhc_result_if;
    logic                       valid;
    logic                       ready;
    logic [swhc_pkg::SUM_W-1:0] hit_count;

    modport source (output valid, output hit_count, input ready);
    modport sink   (input valid, input hit_count, output ready);
endinterface

// ----- design/swhc_ctrl.sv -----
// Sequencer for the clearing pass, hit update and query sweep.
module swhc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_mode,
    output logic              item_ready,
    input  swhc_pkg::status_t status,
    output swhc_pkg::cmd_t    cmd
);
    import swhc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HRD,
        ST_HWR,
        ST_SUM,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_mode == MODE_QUERY)
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.sum_clr = 1'b1;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_done)
                begin
                    state_next = ST_HRD;
                end
            end
            ST_HRD:
            begin
                cmd.hit_rd = 1'b1;
                state_next = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.hit_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                cmd.sum_rd = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/swhc_dp.sv -----
// Bucket memory, slot remainder, window sum pipe and output register.
module swhc_dp #(
    parameter int WINDOW = swhc_pkg::WINDOW_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [swhc_pkg::TS_W-1:0] timestamp,
    input  swhc_pkg::cmd_t            cmd,
    output swhc_pkg::status_t         status,
    swhc_result_if.source             result
);
    import swhc_pkg::*;

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ENTRY_W = TS_W + COUNT_W;
    localparam int AGE_W   = TS_W + 1;

    // reciprocal of WINDOW, scaled so the quotient is exact for every timestamp
    localparam int RSHIFT  = TS_W + SLOT_W;
    localparam int RECIP_W = TS_W + 2;
    localparam int PROD_W  = TS_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // bucket store: {tag, count}
    logic [ENTRY_W-1:0] mem [WINDOW];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [TS_W-1:0]    ts_reg;
    logic [TS_W-1:0]    quot_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SLOT_W-1:0]  rem_reg;
    logic [SLOT_W-1:0]  idx_reg;

    logic               rd_v_reg;
    logic               qual_v_reg;
    logic [COUNT_W-1:0] qual_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic               out_v_reg;
    logic [SUM_W-1:0]   out_reg;

    // slot: first step takes the quotient, second multiplies back and subtracts
    logic [TS_W-1:0]    quot_next;
    logic [SLOT_W-1:0]  rem_next;

    assign quot_next = TS_W'((PROD_W'(ts_reg) * PROD_W'(RECIP)) >> RSHIFT);
    assign rem_next  = SLOT_W'(ts_reg - quot_reg * TS_W'(WINDOW));

    // hit update
    logic [TS_W-1:0]    rd_tag;
    logic [COUNT_W-1:0] rd_count;
    logic [ENTRY_W-1:0] hit_entry;

    assign rd_tag   = rd_data_reg[ENTRY_W-1:COUNT_W];
    assign rd_count = rd_data_reg[COUNT_W-1:0];

    always_comb
    begin
        if (rd_tag == ts_reg)
        begin
            if (rd_count == COUNT_MAX)
            begin
                hit_entry = rd_data_reg;
            end
            else
            begin
                hit_entry = {rd_tag, rd_count + COUNT_W'(1)};
            end
        end
        else
        begin
            hit_entry = {ts_reg, COUNT_W'(1)};
        end
    end

    // window test on signed age
    logic signed [AGE_W-1:0] age;
    logic                    in_win;

    assign age    = $signed({1'b0, ts_reg}) - $signed({1'b0, rd_tag});
    assign in_win = (age < $signed(AGE_W'(WINDOW)));

    logic [SUM_W:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(qual_reg);

    // memory ports
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [SLOT_W-1:0]  mem_raddr;

    assign mem_we    = cmd.clr_wr | cmd.hit_wr;
    assign mem_waddr = cmd.hit_wr ? rem_reg : idx_reg;
    assign mem_wdata = cmd.hit_wr ? hit_entry : '0;
    assign mem_re    = cmd.hit_rd | cmd.sum_rd;
    assign mem_raddr = cmd.hit_rd ? rem_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ts_reg  <= timestamp;
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        qual_reg <= in_win ? rd_count : '0;
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (qual_v_reg)
        begin
            sum_reg <= (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_reg <= sum_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            idx_reg    <= '0;
            rd_v_reg   <= 1'b0;
            qual_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.clr_wr || cmd.sum_rd)
            begin
                idx_reg <= status.idx_last ? '0 : idx_reg + SLOT_W'(1);
            end

            rd_v_reg   <= cmd.sum_rd;
            qual_v_reg <= rd_v_reg;

            if (cmd.out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign status.mod_done  = (step_reg == STEP_W'(MOD_STEPS - 1));
    assign status.idx_last  = (idx_reg == SLOT_W'(WINDOW - 1));
    assign status.pipe_busy = rd_v_reg | qual_v_reg;
    assign status.out_free  = !out_v_reg || result.ready;

    assign result.valid     = out_v_reg;
    assign result.hit_count = out_reg;

endmodule

// ----- design/sliding_window_hit_counter.sv -----
// Top level of the bucketed sliding-window hit counter.
//
//   channel  dir  beat fields           notes
//   item     in   mode, timestamp       mode 0 = hit, 1 = query
//   result   out  hit_count             one beat per query
//
// A hit takes the beat, the bucket slot steps (reciprocal multiply, then
// multiply back and subtract), one bucket read and one bucket write.
// A query takes the beat, one memory read per bucket, a drain of the read,
// compare and accumulate stages, and a load of the output register, which
// waits while that register still holds a result that was not taken.
// After reset a clearing pass zeroes every bucket; item.ready stays low until
// it is done. A finished sum waits in the output register while the next item
// is taken; only a later query stalls on a full result.
module sliding_window_hit_counter #(
    parameter int WINDOW = swhc_pkg::WINDOW_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    swhc_item_if.sink     item,
    swhc_result_if.source result
);
    import swhc_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    ready;

    swhc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_mode  (item.mode),
        .item_ready (ready),
        .status     (status),
        .cmd        (cmd)
    );

    swhc_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .timestamp (item.timestamp),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign item.ready = ready;

endmodule

// ----- tb/tb_sliding_window_hit_counter.sv -----
// Self-checking testbench for the sliding-window hit counter: directed table, then random traffic.
module tb_sliding_window_hit_counter;

    timeunit 1ns;
    timeprecision 1ps;

    import swhc_pkg::*;

    localparam int WINDOW = WINDOW_DEF;

    typedef logic [TS_W-1:0]  stamp_t;
    typedef logic [SUM_W-1:0] total_t;

    localparam int     PREDICT    = -1;     // no typed-in answer, use the predictor
    localparam stamp_t TS_MAX     = '1;

    typedef struct {
        bit     mode;
        stamp_t ts;
        int     reps;
        int     want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    swhc_item_if   item_ch();
    swhc_result_if result_ch();

    sliding_window_hit_counter #(.WINDOW(WINDOW)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predictor state
    stamp_t           slot_tag  [WINDOW];
    logic [COUNT_W-1:0] slot_hits [WINDOW];
    total_t           count_due [$];

    int  errors  = 0;
    bit  no_gaps = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what);
        $display("ERROR t=%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void tally_hit(input stamp_t ts);
        int s;
        s = int'(ts % WINDOW);
        if (slot_tag[s] == ts)
        begin
            if (slot_hits[s] != COUNT_MAX)
                slot_hits[s] = slot_hits[s] + 1'b1;
        end
        else
        begin
            slot_tag[s]  = ts;
            slot_hits[s] = COUNT_W'(1);
        end
    endfunction

    function automatic total_t window_sum(input stamp_t ts);
        longint age;
        longint total;
        total = 0;
        for (int i = 0; i < WINDOW; i++)
        begin
            // tags ahead of the query time give a negative age and count as inside
            age = longint'(ts) - longint'(slot_tag[i]);
            if (age < WINDOW)
            begin
                total += slot_hits[i];
                if (total > longint'(SUM_MAX))
                    total = longint'(SUM_MAX);
            end
        end
        return total_t'(total);
    endfunction

    task automatic send_beat(input bit mode, input stamp_t ts, input int want);
        while (!no_gaps && $urandom_range(0, 99) < 8)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.timestamp <= ts;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (mode == MODE_HIT)
            tally_hit(ts);
        else if (want == PREDICT)
            count_due.push_back(window_sum(ts));
        else
            count_due.push_back(total_t'(want));
    endtask

    // result side: random back-pressure, check each beat against the oldest query
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (count_due.size() == 0)
                    report($sformatf("hit_count %0d with no query pending",
                                     result_ch.hit_count));
                else
                begin
                    total_t want;
                    want = count_due.pop_front();
                    if (result_ch.hit_count !== want)
                        report($sformatf("hit_count %0d, expected %0d",
                                         result_ch.hit_count, want));
                end
            end
            result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 8);
        end
        else
        begin
            result_ch.ready <= 1'b0;
        end
    end

    initial
    begin
        stim_row_t plan [17];
        stamp_t    ts_now;
        stamp_t    ts;
        int        pick;

        rst_n              = 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.mode       <= MODE_HIT;
        item_ch.timestamp  <= '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            slot_tag[i]  = '0;
            slot_hits[i] = '0;
        end

        plan = '{
            '{MODE_QUERY, 0,      1,     0},       // empty store
            '{MODE_QUERY, TS_MAX, 1,     0},
            '{MODE_HIT,   5,      3,     PREDICT},
            '{MODE_QUERY, 5,      1,     3},
            '{MODE_HIT,   305,    1,     PREDICT}, // same slot, newer tag takes over
            '{MODE_QUERY, 305,    1,     1},
            '{MODE_QUERY, 604,    1,     1},       // age WINDOW-1: still inside
            '{MODE_QUERY, 605,    1,     0},       // age WINDOW: out
            '{MODE_HIT,   299,    1,     PREDICT},
            '{MODE_HIT,   100,    1,     PREDICT},
            '{MODE_QUERY, 50,     1,     PREDICT}, // time going backwards
            '{MODE_HIT,   TS_MAX, 1,     PREDICT},
            '{MODE_QUERY, TS_MAX, 1,     1},
            '{MODE_HIT,   1000,   40,    PREDICT}, // burst of hits in one second
            '{MODE_QUERY, 1000,   1,     PREDICT},
            '{MODE_HIT,   1000,   1,     PREDICT},
            '{MODE_QUERY, 1299,   1,     PREDICT}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
                send_beat(plan[r].mode, plan[r].ts, plan[r].want);

        // mostly non-decreasing time with bursts of hits per second,
        // plus jumps anywhere in the range and stray old timestamps
        ts_now = 1299;
        for (int n = 0; n < 1800; n++)
        begin
            no_gaps = (n >= 700 && n < 1100);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                ts = ts_now;
            else if (pick < 85)
                ts = ts_now + stamp_t'($urandom_range(1, 3));
            else if (pick < 92)
                ts = ts_now + stamp_t'($urandom_range(4, WINDOW + 20));
            else if (pick < 95)
                ts = stamp_t'($urandom());
            else
                ts = ts_now - stamp_t'($urandom_range(1, WINDOW + 100));
            if (pick < 95)
                ts_now = ts;
            send_beat(($urandom_range(0, 99) < 55) ? MODE_HIT : MODE_QUERY, ts, PREDICT);
        end
        no_gaps = 1'b0;

        item_ch.valid <= 1'b0;
        while (count_due.size() != 0)
            @(posedge clk);
        repeat (WINDOW + 40) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
